// File: rtl/fpa_pkg.sv
// shared types, constants and command codes for the fixed-point alu
package fpa_pkg;

	localparam int WORD_W        = 32;
	localparam int FRAC_BITS_DEF = 8;

	localparam logic signed [WORD_W-1:0] WORD_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [WORD_W-1:0] WORD_MIN = 32'sh8000_0000;

	typedef enum logic [3:0] {
		CMD_ADD      = 4'd0,
		CMD_SUB      = 4'd1,
		CMD_MUL      = 4'd2,
		CMD_DIV      = 4'd3,
		CMD_INC      = 4'd4,
		CMD_DEC      = 4'd5,
		CMD_COMPARE  = 4'd6,
		CMD_MIN      = 4'd7,
		CMD_MAX      = 4'd8,
		CMD_FROM_INT = 4'd9,
		CMD_TO_INT   = 4'd10
	} cmd_t;

	typedef struct packed {
		logic        [3:0]        command;
		logic signed [WORD_W-1:0] operand_a;
		logic signed [WORD_W-1:0] operand_b;
	} in_t;

	typedef struct packed {
		logic signed [WORD_W-1:0] result_value;
		logic                     is_less;
		logic                     is_equal;
		logic                     is_greater;
		logic                     overflow;
		logic                     divide_by_zero;
	} out_t;

	// side information that rides along the divider stages
	typedef struct packed {
		logic        [3:0]          command;
		logic                       lt;
		logic                       eq;
		logic                       gt;
		logic signed [WORD_W-1:0]   res;
		logic                       ov;
		logic                       dz;
		logic                       neg;
		logic        [2*WORD_W-1:0] wide;
	} meta_t;

endpackage

// File: rtl/fixed_point_alu_unit.sv
// a transaction passes the input stage, the divider setup stage, the restoring divider with
// one quotient bit per stage, and the output register before its result shows
// throughput: one transaction per cycle, busy is always low and done strobes for one cycle
// the receiver cannot stall, every command runs through the same pipeline length
// reset clears only the valid bits; the datapath holds no state between transactions
module fixed_point_alu_unit #(
	parameter int FRAC_BITS = fpa_pkg::FRAC_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	output logic         busy,
	input  fpa_pkg::in_t request,
	output logic         done,
	output fpa_pkg::out_t result
);
	import fpa_pkg::*;

	localparam int NW  = WORD_W + FRAC_BITS;
	localparam int LAT = NW + 2;

	// input stage
	logic                     v_s1;
	logic        [3:0]        cmd_s1;
	logic signed [WORD_W-1:0] a_s1;
	logic signed [WORD_W-1:0] b_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		cmd_s1 <= request.command;
		a_s1   <= request.operand_a;
		b_s1   <= request.operand_b;
	end

	assign busy = 1'b0;

	// simple commands, product and divider setup
	logic        [WORD_W:0]     add_w;
	logic        [WORD_W:0]     sub_w;
	logic        [WORD_W:0]     inc_w;
	logic        [WORD_W:0]     dec_w;
	logic signed [2*WORD_W-1:0] fi_w;
	logic        [WORD_W-1:0]   amag;
	logic        [WORD_W-1:0]   bmag;
	meta_t                      meta_nx;

	always_comb begin
		add_w = {a_s1[WORD_W-1], a_s1} + {b_s1[WORD_W-1], b_s1};
		sub_w = {a_s1[WORD_W-1], a_s1} - {b_s1[WORD_W-1], b_s1};
		inc_w = {a_s1[WORD_W-1], a_s1} + (WORD_W+1)'(1);
		dec_w = {a_s1[WORD_W-1], a_s1} - (WORD_W+1)'(1);
		fi_w  = (2*WORD_W)'(a_s1) <<< FRAC_BITS;
		amag  = a_s1[WORD_W-1] ? WORD_W'(-a_s1) : WORD_W'(a_s1);
		bmag  = b_s1[WORD_W-1] ? WORD_W'(-b_s1) : WORD_W'(b_s1);

		meta_nx         = '0;
		meta_nx.command = cmd_s1;
		meta_nx.lt      = a_s1 < b_s1;
		meta_nx.eq      = a_s1 == b_s1;
		meta_nx.gt      = a_s1 > b_s1;
		meta_nx.neg     = a_s1[WORD_W-1] != b_s1[WORD_W-1];
		meta_nx.wide    = (2*WORD_W)'(a_s1 * b_s1);

		case (cmd_t'(cmd_s1))
			CMD_ADD: begin
				meta_nx.ov  = add_w[WORD_W] != add_w[WORD_W-1];
				meta_nx.res = meta_nx.ov ? (add_w[WORD_W] ? WORD_MIN : WORD_MAX)
				                         : add_w[WORD_W-1:0];
			end
			CMD_SUB: begin
				meta_nx.ov  = sub_w[WORD_W] != sub_w[WORD_W-1];
				meta_nx.res = meta_nx.ov ? (sub_w[WORD_W] ? WORD_MIN : WORD_MAX)
				                         : sub_w[WORD_W-1:0];
			end
			CMD_INC: begin
				meta_nx.ov  = inc_w[WORD_W] != inc_w[WORD_W-1];
				meta_nx.res = meta_nx.ov ? WORD_MAX : inc_w[WORD_W-1:0];
			end
			CMD_DEC: begin
				meta_nx.ov  = dec_w[WORD_W] != dec_w[WORD_W-1];
				meta_nx.res = meta_nx.ov ? WORD_MIN : dec_w[WORD_W-1:0];
			end
			CMD_MIN: meta_nx.res = (a_s1 < b_s1) ? a_s1 : b_s1;
			CMD_MAX: meta_nx.res = (a_s1 < b_s1) ? b_s1 : a_s1;
			CMD_FROM_INT: begin
				meta_nx.ov  = (fi_w > 64'(WORD_MAX)) || (fi_w < 64'(WORD_MIN));
				meta_nx.res = meta_nx.ov ? (a_s1[WORD_W-1] ? WORD_MIN : WORD_MAX)
				                         : fi_w[WORD_W-1:0];
			end
			CMD_TO_INT: meta_nx.res = a_s1 >>> FRAC_BITS;
			CMD_DIV: begin
				meta_nx.dz  = b_s1 == '0;
				meta_nx.res = a_s1[WORD_W-1] ? WORD_MIN : WORD_MAX;
			end
			default: meta_nx.res = '0;
		endcase
	end

	// divider pipeline, index 0 is the setup stage
	logic                v_sk    [0:NW];
	logic [WORD_W-1:0]   rem_sk  [0:NW];
	logic [NW-1:0]       num_sk  [0:NW];
	logic [NW-1:0]       quo_sk  [0:NW];
	logic [WORD_W-1:0]   den_sk  [0:NW];
	meta_t               meta_sk [0:NW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_sk[0] <= 1'b0;
		end else begin
			v_sk[0] <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		rem_sk[0]  <= '0;
		num_sk[0]  <= {amag, FRAC_BITS'(0)};
		quo_sk[0]  <= '0;
		den_sk[0]  <= bmag;
		meta_sk[0] <= meta_nx;
	end

	for (genvar k = 1; k <= NW; k++) begin : g_div
		logic [WORD_W:0] trial;
		logic            ge;
		meta_t           meta_k;

		always_comb begin
			trial  = {rem_sk[k-1], num_sk[k-1][NW-1]};
			ge     = trial >= {1'b0, den_sk[k-1]};
			meta_k = meta_sk[k-1];
			// first stage turns the product into its rounded magnitude
			if (k == 1) begin
				meta_k.neg  = meta_sk[0].wide[2*WORD_W-1];
				meta_k.wide = ((meta_sk[0].wide[2*WORD_W-1] ? -meta_sk[0].wide
				                                             : meta_sk[0].wide)
				               + ((2*WORD_W)'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
				if (cmd_t'(meta_sk[0].command) == CMD_DIV) begin
					meta_k.neg = meta_sk[0].neg;
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_sk[k] <= 1'b0;
			end else begin
				v_sk[k] <= v_sk[k-1];
			end
		end

		always_ff @(posedge clk) begin
			rem_sk[k]  <= ge ? WORD_W'(trial - {1'b0, den_sk[k-1]}) : trial[WORD_W-1:0];
			num_sk[k]  <= {num_sk[k-1][NW-2:0], 1'b0};
			quo_sk[k]  <= {quo_sk[k-1][NW-2:0], ge};
			den_sk[k]  <= den_sk[k-1];
			meta_sk[k] <= meta_k;
		end
	end

	// rounding and saturation for multiply and divide
	logic                       rnd;
	logic        [NW:0]         qm;
	logic        [2*WORD_W-1:0] mag;
	out_t                       res_nx;
	meta_t                      mt;

	always_comb begin
		mt  = meta_sk[NW];
		rnd = {rem_sk[NW], 1'b0} >= {1'b0, den_sk[NW]};
		qm  = (NW+1)'(quo_sk[NW]) + (NW+1)'(rnd);
		mag = (cmd_t'(mt.command) == CMD_DIV) ? (2*WORD_W)'(qm) : mt.wide;

		res_nx                = '0;
		res_nx.is_less        = mt.lt;
		res_nx.is_equal       = mt.eq;
		res_nx.is_greater     = mt.gt;
		res_nx.result_value   = mt.res;
		res_nx.overflow       = mt.ov;
		res_nx.divide_by_zero = mt.dz;

		if ((cmd_t'(mt.command) == CMD_MUL) ||
		    ((cmd_t'(mt.command) == CMD_DIV) && !mt.dz)) begin
			if (mt.neg) begin
				res_nx.overflow     = mag > (2*WORD_W)'(64'h8000_0000);
				res_nx.result_value = res_nx.overflow ? WORD_MIN : -mag[WORD_W-1:0];
			end else begin
				res_nx.overflow     = mag > (2*WORD_W)'(64'h7FFF_FFFF);
				res_nx.result_value = res_nx.overflow ? WORD_MAX : mag[WORD_W-1:0];
			end
		end
	end

	// output register
	logic done_q;
	out_t result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= v_sk[NW];
		end
	end

	always_ff @(posedge clk) begin
		result_q <= res_nx;
	end

	assign done   = done_q;
	assign result = result_q;

	// checks that every start is answered by a done strobe once it has passed the whole pipeline
	a_latency : assert property (@(posedge clk) disable iff (!arst_n)
		start |=> ##(LAT) done)
		else $error("transaction did not complete after the pipeline latency");

	a_cmp_onehot : assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $onehot({result.is_less, result.is_equal, result.is_greater}))
		else $error("compare flags not one-hot");

	a_dz_no_ov : assert property (@(posedge clk) disable iff (!arst_n)
		done && result.divide_by_zero |-> !result.overflow)
		else $error("divide by zero also flagged overflow");

	a_ov_sat : assert property (@(posedge clk) disable iff (!arst_n)
		done && result.overflow |->
			(result.result_value == WORD_MAX) || (result.result_value == WORD_MIN))
		else $error("overflow without a saturated result");

endmodule

// File: tb/sv/fixed_point_alu_unit_tb.sv
// self-checking testbench for the fixed-point alu: directed corners, then random commands
`timescale 1ns / 100ps

module fixed_point_alu_unit_tb;
	import fpa_pkg::*;

	localparam int FB = FRAC_BITS_DEF;
	localparam int LATENCY = FB + 34;
	localparam int RANDOM_COUNT = 1300;
	localparam longint CYCLE_LIMIT = 200000;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	in_t request;
	logic done;
	out_t result;

	in_t pending_q[$];
	out_t expected_q[$];
	int mismatch_count = 0;
	int result_count = 0;
	longint cycle_count = 0;
	bit stimulus_loaded = 0;
	bit hold_for_drain = 0;
	int sender_gap = 0;
	int sender_items = 0;
	int quiet_after = 0;

	fixed_point_alu_unit #(.FRAC_BITS(FB)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.request(request),
		.done(done),
		.result(result)
	);

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	function automatic logic signed [31:0] saturate(input logic signed [127:0] v, inout logic ov);
		if (v > 128'sd2147483647) begin
			ov = 1;
			return WORD_MAX;
		end
		if (v < -128'sd2147483648) begin
			ov = 1;
			return WORD_MIN;
		end
		return v[31:0];
	endfunction

	// magnitude-based rounding, half away from zero
	function automatic logic signed [127:0] round_quotient(input logic signed [127:0] num,
			input logic signed [127:0] den);
		logic signed [127:0] n;
		logic signed [127:0] d;
		logic signed [127:0] q;
		n = num < 0 ? -num : num;
		d = den < 0 ? -den : den;
		q = (2 * n + d) / (2 * d);
		return ((num < 0) != (den < 0)) ? -q : q;
	endfunction

	function automatic out_t alu_result(input in_t req);
		out_t o;
		logic signed [127:0] a;
		logic signed [127:0] b;
		logic signed [127:0] one;
		logic ov;
		a = req.operand_a;
		b = req.operand_b;
		one = 1;
		ov = 0;
		o = '0;
		case (req.command)
			CMD_ADD: o.result_value = saturate(a + b, ov);
			CMD_SUB: o.result_value = saturate(a - b, ov);
			CMD_MUL: o.result_value = saturate(round_quotient(a * b, one <<< FB), ov);
			CMD_DIV: begin
				if (b == 0) begin
					o.divide_by_zero = 1;
					o.result_value = a < 0 ? WORD_MIN : WORD_MAX;
				end else begin
					o.result_value = saturate(round_quotient(a <<< FB, b), ov);
				end
			end
			CMD_INC: o.result_value = saturate(a + 1, ov);
			CMD_DEC: o.result_value = saturate(a - 1, ov);
			CMD_COMPARE: o.result_value = '0;
			CMD_MIN: o.result_value = a < b ? req.operand_a : req.operand_b;
			CMD_MAX: o.result_value = a < b ? req.operand_b : req.operand_a;
			CMD_FROM_INT: o.result_value = saturate(a <<< FB, ov);
			CMD_TO_INT: o.result_value = req.operand_a >>> FB;
			default: o.result_value = '0;
		endcase
		o.overflow = ov;
		o.is_less = a < b;
		o.is_equal = a == b;
		o.is_greater = a > b;
		return o;
	endfunction

	function automatic logic signed [31:0] random_operand();
		case ($urandom_range(0, 5))
			0: return $urandom;
			1: return $signed($urandom_range(0, 1023)) - 512;
			2: return $urandom_range(0, 1) ? WORD_MAX - $urandom_range(0, 3)
				: WORD_MIN + $urandom_range(0, 3);
			3: return $signed($urandom_range(0, 131071)) - 65536;
			4: return '0;
			default: return $signed($urandom) >>> $urandom_range(0, 31);
		endcase
	endfunction

	task automatic queue_item(input logic [3:0] c, input logic signed [31:0] a,
			input logic signed [31:0] b);
		in_t r;
		r.command = c;
		r.operand_a = a;
		r.operand_b = b;
		pending_q.push_back(r);
	endtask

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		mismatch_count++;
		$display("mismatch at transaction %0d: %s got %h expected %h", result_count, what, got, want);
	endtask

	// directed corners, then random traffic
	initial begin
		cmd_t c;
		queue_item(CMD_ADD, WORD_MAX, 32'sd1);
		queue_item(CMD_ADD, WORD_MIN, -32'sd1);
		queue_item(CMD_SUB, WORD_MIN, 32'sd1);
		queue_item(CMD_SUB, WORD_MAX, WORD_MIN);
		queue_item(CMD_MUL, 32'sd384, 32'sd1);
		queue_item(CMD_MUL, -32'sd384, 32'sd1);
		queue_item(CMD_MUL, WORD_MIN, WORD_MIN);
		queue_item(CMD_MUL, WORD_MAX, WORD_MIN);
		queue_item(CMD_DIV, 32'sd0, 32'sd0);
		queue_item(CMD_DIV, -32'sd5, 32'sd0);
		queue_item(CMD_DIV, WORD_MIN, -32'sd1);
		queue_item(CMD_DIV, 32'sd1, 32'sd512);
		queue_item(CMD_DIV, -32'sd3, 32'sd2048);
		queue_item(CMD_INC, WORD_MAX, 32'sd0);
		queue_item(CMD_DEC, WORD_MIN, 32'sd0);
		queue_item(CMD_COMPARE, 32'sd7, 32'sd7);
		queue_item(CMD_MIN, 32'sd9, 32'sd9);
		queue_item(CMD_MAX, WORD_MIN, WORD_MAX);
		queue_item(CMD_FROM_INT, WORD_MAX, 32'sd0);
		queue_item(CMD_FROM_INT, WORD_MIN, 32'sd0);
		queue_item(CMD_TO_INT, -32'sd1, 32'sd0);
		queue_item(CMD_TO_INT, WORD_MAX, 32'sd0);
		queue_item(4'd11, 32'sd1, 32'sd2);
		queue_item(4'd15, -32'sd1, 32'sd1);
		for (int i = 0; i < RANDOM_COUNT; i++) begin
			c = cmd_t'($urandom_range(0, 10));
			queue_item($urandom_range(0, 15) == 0 ? 4'($urandom_range(11, 15)) : 4'(c),
				random_operand(), $urandom_range(0, 9) == 0 ? 32'sd0 : random_operand());
		end
		stimulus_loaded = 1;
	end

	initial begin
		arst_n = 0;
		start = 0;
		request = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1;
	end

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 0;
			request <= '0;
		end else begin
			if (start && !busy) begin
				expected_q.push_back(alu_result(request));
				sender_items++;
				if (sender_items == 200)
					hold_for_drain = 1;
			end
			if (hold_for_drain && expected_q.size() == 0 && !(start && !busy))
				hold_for_drain = 0;
			if (sender_gap > 0)
				sender_gap--;
			if (!(start && busy)) begin
				if (stimulus_loaded && pending_q.size() > 0 && !hold_for_drain && sender_gap == 0
						&& !(start && !busy && sender_items == 200)) begin
					if (pending_q.size() > 150 && $urandom_range(0, 9) == 0) begin
						sender_gap = $urandom_range(1, 12);
						start <= 0;
					end else begin
						start <= 1;
						request <= pending_q.pop_front();
					end
				end else begin
					start <= 0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		out_t want;
		if (arst_n && done) begin
			if (expected_q.size() == 0) begin
				report_mismatch("unexpected result_value", result.result_value, '0);
			end else begin
				want = expected_q.pop_front();
				if (result.result_value !== want.result_value)
					report_mismatch("result_value", result.result_value, want.result_value);
				if (result.is_less !== want.is_less)
					report_mismatch("is_less", result.is_less, want.is_less);
				if (result.is_equal !== want.is_equal)
					report_mismatch("is_equal", result.is_equal, want.is_equal);
				if (result.is_greater !== want.is_greater)
					report_mismatch("is_greater", result.is_greater, want.is_greater);
				if (result.overflow !== want.overflow)
					report_mismatch("overflow", result.overflow, want.overflow);
				if (result.divide_by_zero !== want.divide_by_zero)
					report_mismatch("divide_by_zero", result.divide_by_zero, want.divide_by_zero);
			end
			result_count++;
		end
	end

	// end of run and watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("Mismatches found");
			$finish;
		end else if (stimulus_loaded && pending_q.size() == 0 && !start
				&& expected_q.size() == 0) begin
			quiet_after++;
			if (quiet_after > LATENCY + 20) begin
				$display("checked %0d transactions across all eleven commands, unused codes too,",
					result_count);
				$display("with saturation, rounding and divide-by-zero corners and random gaps");
				if (mismatch_count == 0)
					$display("No mismatches found");
				else
					$display("Mismatches found");
				$finish;
			end
		end else begin
			quiet_after = 0;
		end
	end

endmodule
